[rtl/asid_ba_pkg.sv]
// shared types and constants for the asid bitmap allocator
package asid_ba_pkg;

	localparam int ID_W = 8;

	// operation codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic            op;
		logic [ID_W-1:0] free_id;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0] granted_id;
		logic            granted;
		logic            exhausted;
		logic            flush_request;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_FREE
	} state_t;

endpackage

[rtl/asid_bitmap_allocator.sv]
// asid bitmap allocator: word-serial search of the in-use bitmap, serial free decode
// alloc: the search starts at the hint word and visits 1 to WORD_COUNT words, wrapping, stepping
//   one bitmap word per cycle through the lowest-clear-bit encoder until a hit or the last word
// free: one word subtracted per cycle until the remainder is below WORD_BITS or the words run out
// throughput: one transfer in flight; the next is accepted once the result loads into the output
//   register, and a finished result waits for a free output slot while the output stalls
// reset: arst_n clears the whole bitmap, the search hint, the state and the output valid at once
module asid_bitmap_allocator #(
	parameter int WORD_COUNT = 8,
	parameter int WORD_BITS  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  asid_ba_pkg::req_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output asid_ba_pkg::res_t  out_data
);
	import asid_ba_pkg::*;

	localparam int WIDX_W = $clog2(WORD_COUNT);
	localparam int WCNT_W = $clog2(WORD_COUNT + 1);
	localparam int BIT_W  = $clog2(WORD_BITS);
	localparam int PROD_W = $clog2(WORD_COUNT * WORD_BITS);

	state_t state_q, state_d;

	logic [WORD_BITS-1:0] bits_q [WORD_COUNT];
	logic [WIDX_W-1:0]    lastw_q;
	logic [WIDX_W-1:0]    idx_q;
	logic [WIDX_W-1:0]    cnt_q;
	logic [ID_W-1:0]      rem_q;
	logic [WCNT_W-1:0]    w_q;
	logic                 fid_nz_q;
	logic                 out_valid_q;
	res_t                 out_data_q;

	logic [WORD_BITS-1:0] search_word;
	logic                 hit;
	logic [BIT_W-1:0]     hit_bit;
	logic [PROD_W-1:0]    gid_full;
	logic                 slot_free;
	logic                 last_word;
	logic                 alloc_done, alloc_commit;
	logic                 rem_low, w_out;
	logic                 free_done, free_commit, free_hit;
	logic [WIDX_W-1:0]    free_widx;
	logic [BIT_W-1:0]     free_bit;
	logic                 in_xfer;
	res_t                 res_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign slot_free = !out_valid_q || out_ready;

	// lowest clear bit of the current word, bit zero of word zero counts as taken
	always_comb begin
		search_word = bits_q[idx_q];
		if (idx_q == '0) begin
			search_word[0] = 1'b1;
		end
		hit     = 1'b0;
		hit_bit = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!search_word[i]) begin
				hit     = 1'b1;
				hit_bit = BIT_W'(i);
			end
		end
	end

	assign gid_full = PROD_W'(idx_q) * PROD_W'(WORD_BITS) + PROD_W'(hit_bit);

	// search and free decode status
	assign last_word    = (cnt_q == WIDX_W'(WORD_COUNT - 1));
	assign alloc_done   = (state_q == ST_ALLOC) && (hit || last_word);
	assign alloc_commit = alloc_done && slot_free;
	assign rem_low      = (rem_q < ID_W'(WORD_BITS));
	assign w_out        = (w_q == WCNT_W'(WORD_COUNT));
	assign free_done    = (state_q == ST_FREE) && (rem_low || w_out);
	assign free_commit  = free_done && slot_free;
	assign free_hit     = rem_low && !w_out && fid_nz_q;
	assign free_widx    = w_q[WIDX_W-1:0];
	assign free_bit     = rem_q[BIT_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = (in_data.op == OP_FREE) ? ST_FREE : ST_ALLOC;
				end
			end
			ST_ALLOC: begin
				if (alloc_commit) begin
					state_d = ST_IDLE;
				end
			end
			ST_FREE: begin
				if (free_commit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// result of the finishing transfer
	always_comb begin
		res_d = '0;
		unique case (state_q)
			ST_ALLOC: begin
				res_d.granted    = hit;
				res_d.exhausted  = !hit;
				res_d.granted_id = hit ? ID_W'(gid_full) : '0;
			end
			ST_FREE: begin
				res_d.flush_request = free_hit;
			end
			default: res_d = '0;
		endcase
	end

	// state, bitmap and search registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			lastw_q  <= '0;
			idx_q    <= '0;
			cnt_q    <= '0;
			rem_q    <= '0;
			w_q      <= '0;
			fid_nz_q <= 1'b0;
			for (int k = 0; k < WORD_COUNT; k++) begin
				bits_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				idx_q    <= lastw_q;
				cnt_q    <= '0;
				rem_q    <= in_data.free_id;
				w_q      <= '0;
				fid_nz_q <= (in_data.free_id != '0);
			end
			// alloc: step to the next word or claim the found bit
			if (state_q == ST_ALLOC) begin
				if (alloc_commit && hit) begin
					bits_q[idx_q][hit_bit] <= 1'b1;
					lastw_q                <= idx_q;
				end else if (!hit && !last_word) begin
					idx_q <= (idx_q == WIDX_W'(WORD_COUNT - 1)) ? '0 : idx_q + 1'b1;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			// free: subtract one word per cycle, then clear the bit if the id is nonzero and in range
			if (state_q == ST_FREE) begin
				if (free_commit && free_hit) begin
					bits_q[free_widx][free_bit] <= 1'b0;
				end else if (!rem_low && !w_out) begin
					rem_q <= rem_q - ID_W'(WORD_BITS);
					w_q   <= w_q + 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (alloc_commit || free_commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (alloc_commit || free_commit) begin
			out_data_q <= res_d;
		end
	end

	// identifier zero is never claimed
	assert property (@(posedge clk) disable iff (!arst_n)
		alloc_commit && hit |-> !(idx_q == '0 && hit_bit == '0))
		else $error("allocation claimed identifier zero");

	// a claimed bit is set in the cycle after the claim
	assert property (@(posedge clk) disable iff (!arst_n)
		alloc_commit && hit |=> bits_q[$past(idx_q)][$past(hit_bit)])
		else $error("claimed bitmap bit not set");

	// search never visits more words than exist
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ALLOC |-> cnt_q <= WIDX_W'(WORD_COUNT - 1))
		else $error("search word count out of range");

	// result flags are exclusive
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_data_q.granted && out_data_q.exhausted) &&
			!(out_data_q.flush_request && (out_data_q.granted || out_data_q.exhausted)))
		else $error("conflicting result flags");

	// a commit only happens into a free output slot
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> $stable(out_data_q))
		else $error("pending result overwritten");

endmodule

[tb/asid_ba_checker.sv]
// checker for the asid bitmap allocator: bitmap prediction and result comparison
`timescale 1ns / 1ps

module asid_ba_checker #(
	parameter int WORD_COUNT = 8,
	parameter int WORD_BITS  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  asid_ba_pkg::req_t in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  asid_ba_pkg::res_t out_data,
	output int                errors,
	output int                pending
);
	import asid_ba_pkg::*;

	// shadow copy of the in-use bitmap and the search hint
	logic [WORD_BITS-1:0] id_map [WORD_COUNT];
	logic [ID_W-1:0]      hint_id;
	res_t                 grant_q[$];

	initial begin
		errors = 0;
		pending = 0;
	end

	// apply one request to the shadow bitmap and work out its result
	task automatic apply_request(input req_t req, output res_t res);
		int  first_word;
		int  word_idx;
		int  bit_idx;
		bit  found;
		res = '0;
		found = 1'b0;
		if (req.op == OP_ALLOC) begin
			first_word = (int'(hint_id) / WORD_BITS) % WORD_COUNT;
			for (int n = 0; n < WORD_COUNT; n++) begin
				word_idx = (first_word + n) % WORD_COUNT;
				for (int j = 0; j < WORD_BITS; j++) begin
					// lowest clear bit, identifier zero is reserved
					if (!found && !id_map[word_idx][j] && !(word_idx == 0 && j == 0)) begin
						id_map[word_idx][j] = 1'b1;
						hint_id = ID_W'(word_idx * WORD_BITS + j);
						res.granted_id = hint_id;
						res.granted = 1'b1;
						found = 1'b1;
					end
				end
			end
			if (!found)
				res.exhausted = 1'b1;
		end else if (req.free_id != '0) begin
			word_idx = int'(req.free_id) / WORD_BITS;
			bit_idx = int'(req.free_id) % WORD_BITS;
			if (word_idx < WORD_COUNT) begin
				id_map[word_idx][bit_idx] = 1'b0;
				res.flush_request = 1'b1;
			end
		end
	endtask

	// count a failure, report only the first few
	task automatic flag_error(input string what, input res_t want, input res_t got);
		errors++;
		if (errors <= 10)
			$display("%0t mismatch (%s): expected id=%0d granted=%0b exhausted=%0b flush=%0b, got id=%0d granted=%0b exhausted=%0b flush=%0b",
				$realtime, what, want.granted_id, want.granted, want.exhausted,
				want.flush_request, got.granted_id, got.granted, got.exhausted,
				got.flush_request);
	endtask

	// compare result transfers first, then record new request transfers
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		if (!arst_n) begin
			for (int w = 0; w < WORD_COUNT; w++)
				id_map[w] = '0;
			hint_id = '0;
			grant_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				got = out_data;
				if (grant_q.size() == 0) begin
					flag_error("unexpected result", '0, got);
				end else begin
					want = grant_q.pop_front();
					if (got.granted_id !== want.granted_id || got.granted !== want.granted ||
						got.exhausted !== want.exhausted ||
						got.flush_request !== want.flush_request)
						flag_error("field", want, got);
				end
			end
			if (in_valid && in_ready) begin
				apply_request(in_data, want);
				grant_q.push_back(want);
			end
		end
		pending = grant_q.size();
	end

endmodule

[tb/tb_asid_bitmap_allocator.sv]
// testbench top for the asid bitmap allocator: stimulus, handshake idling and verdict
`timescale 1ns / 1ps

module tb_asid_bitmap_allocator;
	import asid_ba_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	res_t out_data;
	int   errors;
	int   pending;

	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;
	int stall_left = 0;
	int recv_cycles = 0;

	asid_bitmap_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	asid_ba_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.errors    (errors),
		.pending   (pending)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#2ms;
		$display("FAIL");
		$finish;
	end

	// idle length: mostly short, a few long, none in calm stretches
	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 75)
			return $urandom_range(0, 2);
		if (r < 93)
			return $urandom_range(3, 8);
		return $urandom_range(15, 40);
	endfunction

	// one request transfer followed by a random gap
	task automatic send_item(input logic op, input logic [ID_W-1:0] id);
		req_t req;
		int   gap;
		req.op = op;
		req.free_id = id;
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		gap = pick_gap(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// result side stalls
	always @(posedge clk) begin
		recv_cycles <= recv_cycles + 1;
		if (recv_cycles % 64 == 0)
			recv_calm <= ($urandom_range(0, 3) == 0);
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!recv_calm && $urandom_range(0, 3) == 0) begin
			stall_left <= pick_gap(1'b0);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// stimulus and verdict
	initial begin
		logic op;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: first grants, reserved id, frees in and out of use, edge ids
		send_item(OP_ALLOC, 8'h00);
		send_item(OP_ALLOC, 8'hff);
		send_item(OP_ALLOC, 8'h00);
		send_item(OP_FREE, 8'h00);
		send_item(OP_FREE, 8'h02);
		send_item(OP_ALLOC, 8'h00);
		send_item(OP_FREE, 8'hff);
		send_item(OP_FREE, 8'h80);
		send_item(OP_FREE, 8'h01);
		send_item(OP_ALLOC, 8'hff);
		send_item(OP_FREE, 8'h03);
		send_item(OP_FREE, 8'h03);
		send_item(OP_FREE, 8'h1f);
		send_item(OP_FREE, 8'h20);

		// fill the whole space, run into exhaustion, hint ends in the top word
		for (int i = 0; i < 262; i++) begin
			if (i % 40 == 0)
				send_calm = ($urandom_range(0, 3) == 0);
			send_item(OP_ALLOC, ID_W'($urandom_range(0, 255)));
		end

		// mixed traffic near full: wrapping search, repeat exhaustion, random frees
		for (int i = 0; i < 375; i++) begin
			if (i % 40 == 0)
				send_calm = ($urandom_range(0, 3) == 0);
			op = ($urandom_range(0, 99) < 55) ? OP_ALLOC : OP_FREE;
			send_item(op, ID_W'($urandom_range(0, 255)));
		end
		in_valid <= 1'b0;

		// drain once the last request is recorded, then allow for a late extra result
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[filelist.f]
rtl/asid_ba_pkg.sv
rtl/asid_bitmap_allocator.sv
tb/asid_ba_checker.sv
tb/tb_asid_bitmap_allocator.sv
